/* sv/i2a_pkg.sv */
// Shared types, codes, constants and helper functions of the integer-to-ASCII formatter.
`timescale 1ns / 1ps
`default_nettype none

package i2a_pkg;

	// Default sizes of the digit store and of the field width limit.
	localparam int MAX_DIGITS_DEF = 32;
	localparam int MAX_WIDTH_DEF  = 62;

	// Field widths of the request and result items.
	localparam int FUNC_W    = 3;
	localparam int VALUE_W   = 64;
	localparam int FW_W      = 6;
	localparam int CHAR_W    = 8;
	localparam int IN_DATA_W = 72;

	// Double-dabble register: 20 BCD digits cover any 64-bit magnitude.
	localparam int BCD_DIGITS = 20;
	localparam int BCD_W      = 4 * BCD_DIGITS;
	localparam int ITER_W     = 7;

	// Sign plus digits, up to MAX_DIGITS + 1.
	localparam int LEN_W = 7;

	// Conversion kinds.
	localparam logic [FUNC_W-1:0] FN_DEC32  = 3'd0;
	localparam logic [FUNC_W-1:0] FN_DEC64  = 3'd1;
	localparam logic [FUNC_W-1:0] FN_HEX32  = 3'd2;
	localparam logic [FUNC_W-1:0] FN_HEX64  = 3'd3;
	localparam logic [FUNC_W-1:0] FN_HEXU32 = 3'd4;
	localparam logic [FUNC_W-1:0] FN_BIN32  = 3'd5;
	localparam logic [FUNC_W-1:0] FN_PTR    = 3'd6;
	localparam logic [FUNC_W-1:0] FN_NONE   = 3'd7;

	// Fixed characters.
	localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_X_LO  = 8'h78;
	localparam logic [CHAR_W-1:0] CH_X_UP  = 8'h58;
	localparam logic [CHAR_W-1:0] CH_A_LO  = 8'h61;
	localparam logic [CHAR_W-1:0] CH_A_UP  = 8'h41;

	// Sequencer states.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CONV,
		ST_PEEL,
		ST_PREP,
		ST_PFX0,
		ST_PFX1,
		ST_SIGN_A,
		ST_PAD,
		ST_SIGN_B,
		ST_DIGITS
	} state_t;

	// Maps one digit value to its ASCII character.
	function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] nib, input logic upper);
		logic [CHAR_W-1:0] res;
		if (nib < 4'd10) begin
			res = CH_ZERO + {4'b0, nib};
		end else if (upper) begin
			res = CH_A_UP + {4'b0, nib} - 8'd10;
		end else begin
			res = CH_A_LO + {4'b0, nib} - 8'd10;
		end
		return res;
	endfunction

	// Adds 3 to every BCD digit that is 5 or more, ahead of the next shift.
	function automatic logic [BCD_W-1:0] bcd_adjust(input logic [BCD_W-1:0] d);
		logic [BCD_W-1:0] res;
		logic [3:0]       nib;
		for (int i = 0; i < BCD_DIGITS; i++) begin
			nib = d[4*i +: 4];
			res[4*i +: 4] = (nib >= 4'd5) ? nib + 4'd3 : nib;
		end
		return res;
	endfunction

endpackage

`default_nettype wire

/* sv/i2a_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module i2a_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

/* sv/integer_to_ascii_formatter_top.sv */
// Top level of the integer-to-ASCII formatter: sequencer, shared digit unit and output register.
`timescale 1ns / 1ps
`default_nettype none

// Converts one number per request into ASCII text (signed decimal, hex with a 0x or 0X prefix,
// binary, or pointer) and sends it one character per result, with tlast on the final
// character. The request carries the kind in s_tuser and the value, minimum width and zero-pad
// flag in s_tdata. A request is taken only while the block is idle; func 7 is taken and
// produces no text. A conversion is accepted, then, for the decimal kinds only, the
// shift-and-add-3 binary-to-BCD unit takes in all 32 (32-bit decimal) or 64 (64-bit decimal)
// value bits, then the same shift register peels the digits into the digit store, one digit per
// cycle, then a setup step follows, and the characters go out one per cycle while the sink keeps
// tready high. The output register lets the next request be taken while the final character
// still waits for the sink.

module integer_to_ascii_formatter_top
	import i2a_pkg::*;
#(
	parameter int MAX_DIGITS = MAX_DIGITS_DEF,
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	// value [63:0], width [69:64], zero-pad flag [70], unused bit [71]
	input  wire logic [IN_DATA_W-1:0] s_tdata,
	// func [2:0]
	input  wire logic [FUNC_W-1:0]    s_tuser,
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	// character [7:0]
	output logic      [CHAR_W-1:0]    m_tdata,
	output logic                      m_tlast
);

	localparam int ADDR_W = $clog2(MAX_DIGITS);
	localparam int CNT_W  = $clog2(MAX_DIGITS + 1);

	state_t state_q, state_d;

	// Request fields.
	logic [FUNC_W-1:0]  in_func;
	logic [VALUE_W-1:0] in_value;
	logic [FW_W-1:0]    in_width;
	logic               in_pz;
	logic               in_fire;
	logic               in_dec;
	logic               in_neg;
	logic [31:0]        mag32;
	logic [VALUE_W-1:0] mag64;
	logic [VALUE_W-1:0] hex_val;
	logic [FW_W-1:0]    w_clamp;
	logic [FW_W-1:0]    w_eff;

	// Item registers.
	logic [FUNC_W-1:0]  kind_q;
	logic               neg_q;
	logic               pz_q;
	logic [FW_W-1:0]    w_q;
	logic [VALUE_W-1:0] bin_q;
	logic [BCD_W-1:0]   dig_q;
	logic [ITER_W-1:0]  iter_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [ADDR_W-1:0]  idx_q, idx_d;
	logic [FW_W-1:0]    pad_q;

	// Shared digit unit.
	logic [BCD_W-1:0]   dab_adj;
	logic [BCD_W-1:0]   dig_shift;
	logic [3:0]         peel_nib;
	logic [CHAR_W-1:0]  peel_char;
	logic               peel_done;
	logic               is_bin;
	logic               is_upper;
	logic               has_prefix;

	// Padding and emission.
	logic [LEN_W-1:0]   len;
	logic [FW_W-1:0]    pad_calc;
	logic [FW_W-1:0]    pad_sel;
	state_t             body_first;
	logic               out_free;
	logic               emit;
	logic [CHAR_W-1:0]  emit_char;
	logic               emit_last;
	logic               ram_we;
	logic [CHAR_W-1:0]  ram_rdata;

	// Output register.
	logic               m_valid_q;
	logic [CHAR_W-1:0]  m_data_q;
	logic               m_last_q;

	// Unpack the request.
	assign in_func  = s_tuser;
	assign in_value = s_tdata[VALUE_W-1:0];
	assign in_width = s_tdata[VALUE_W +: FW_W];
	assign in_pz    = s_tdata[VALUE_W + FW_W];
	assign s_tready = (state_q == ST_IDLE);
	assign in_fire  = s_tvalid && s_tready;

	// Sign, magnitude and effective width of the incoming number.
	always_comb begin
		in_dec  = (in_func == FN_DEC32) || (in_func == FN_DEC64);
		in_neg  = ((in_func == FN_DEC32) && in_value[31]) ||
		          ((in_func == FN_DEC64) && in_value[VALUE_W-1]);
		mag32   = in_value[31] ? 32'(32'd0 - in_value[31:0]) : in_value[31:0];
		mag64   = in_value[VALUE_W-1] ? VALUE_W'(64'd0 - in_value) : in_value;
		hex_val = (in_func == FN_HEX64) ? in_value : {32'b0, in_value[31:0]};
		w_clamp = (in_width > FW_W'(MAX_WIDTH)) ? FW_W'(MAX_WIDTH) : in_width;
		if (in_func == FN_PTR) begin
			w_eff = (w_clamp > 6'd2) ? w_clamp - 6'd2 : '0;
		end else begin
			w_eff = w_clamp;
		end
	end

	// Digit unit: BCD adjust for conversion, right shift and digit lookup for peeling.
	always_comb begin
		is_bin     = (kind_q == FN_BIN32);
		is_upper   = (kind_q == FN_HEXU32);
		has_prefix = (kind_q == FN_HEX32) || (kind_q == FN_HEX64) ||
		             (kind_q == FN_HEXU32) || (kind_q == FN_PTR);
		dab_adj    = bcd_adjust(dig_q);
		dig_shift  = is_bin ? (dig_q >> 1) : (dig_q >> 4);
		peel_nib   = is_bin ? {3'b0, dig_q[0]} : dig_q[3:0];
		peel_char  = hex_char(peel_nib, is_upper);
		peel_done  = (dig_shift == '0);
	end

	// Padding needed ahead of the digits, with the sign before zero padding and after space padding.
	always_comb begin
		len      = LEN_W'(cnt_q) + LEN_W'(neg_q);
		pad_calc = ({1'b0, w_q} > len) ? FW_W'({1'b0, w_q} - len) : '0;
		pad_sel  = (state_q == ST_PREP) ? pad_calc : pad_q;
		if (neg_q && pz_q && (pad_sel != '0)) begin
			body_first = ST_SIGN_A;
		end else if (pad_sel != '0) begin
			body_first = ST_PAD;
		end else if (neg_q) begin
			body_first = ST_SIGN_B;
		end else begin
			body_first = ST_DIGITS;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire && (in_func != FN_NONE)) begin
					state_d = in_dec ? ST_CONV : ST_PEEL;
				end
			end
			ST_CONV: begin
				if (iter_q == ITER_W'(1)) begin
					state_d = ST_PEEL;
				end
			end
			ST_PEEL: begin
				if (peel_done) begin
					state_d = ST_PREP;
				end
			end
			ST_PREP: begin
				state_d = has_prefix ? ST_PFX0 : body_first;
			end
			ST_PFX0: begin
				if (emit) begin
					state_d = ST_PFX1;
				end
			end
			ST_PFX1: begin
				if (emit) begin
					state_d = body_first;
				end
			end
			ST_SIGN_A: begin
				if (emit) begin
					state_d = ST_PAD;
				end
			end
			ST_PAD: begin
				if (emit && (pad_q == FW_W'(1))) begin
					state_d = (neg_q && !pz_q) ? ST_SIGN_B : ST_DIGITS;
				end
			end
			ST_SIGN_B: begin
				if (emit) begin
					state_d = ST_DIGITS;
				end
			end
			ST_DIGITS: begin
				if (emit && (idx_q == '0)) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Sequencer outputs: character to emit, store write and store read index.
	assign out_free = !m_valid_q || m_tready;

	always_comb begin
		emit      = 1'b0;
		emit_char = CH_ZERO;
		emit_last = 1'b0;
		ram_we    = 1'b0;
		idx_d     = idx_q;
		unique case (state_q)
			ST_PEEL: begin
				ram_we = (cnt_q < CNT_W'(MAX_DIGITS));
			end
			ST_PREP: begin
				idx_d = ADDR_W'(cnt_q - CNT_W'(1));
			end
			ST_PFX0: begin
				emit      = out_free;
				emit_char = CH_ZERO;
			end
			ST_PFX1: begin
				emit      = out_free;
				emit_char = is_upper ? CH_X_UP : CH_X_LO;
			end
			ST_SIGN_A, ST_SIGN_B: begin
				emit      = out_free;
				emit_char = CH_MINUS;
			end
			ST_PAD: begin
				emit      = out_free;
				emit_char = pz_q ? CH_ZERO : CH_SPACE;
			end
			ST_DIGITS: begin
				emit      = out_free;
				emit_char = ram_rdata;
				emit_last = (idx_q == '0);
				if (out_free) begin
					idx_d = idx_q - ADDR_W'(1);
				end
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Item registers and the shared shift register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q  <= '0;
			kind_q <= FN_DEC32;
			neg_q  <= 1'b0;
			pz_q   <= 1'b0;
			w_q    <= '0;
			bin_q  <= '0;
			dig_q  <= '0;
			iter_q <= '0;
			cnt_q  <= '0;
			pad_q  <= '0;
		end else begin
			idx_q <= idx_d;
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						kind_q <= in_func;
						neg_q  <= in_neg;
						pz_q   <= in_pz;
						w_q    <= w_eff;
						cnt_q  <= '0;
						if (in_dec) begin
							bin_q  <= (in_func == FN_DEC32) ? {mag32, 32'b0} : mag64;
							dig_q  <= '0;
							iter_q <= (in_func == FN_DEC32) ? ITER_W'(32) : ITER_W'(64);
						end else begin
							dig_q <= BCD_W'(hex_val);
						end
					end
				end
				ST_CONV: begin
					dig_q  <= {dab_adj[BCD_W-2:0], bin_q[VALUE_W-1]};
					bin_q  <= bin_q << 1;
					iter_q <= iter_q - ITER_W'(1);
				end
				ST_PEEL: begin
					dig_q <= dig_shift;
					if (cnt_q < CNT_W'(MAX_DIGITS)) begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				ST_PREP: begin
					pad_q <= pad_calc;
				end
				ST_PAD: begin
					if (emit) begin
						pad_q <= pad_q - FW_W'(1);
					end
				end
				default: begin
					pad_q <= pad_q;
				end
			endcase
		end
	end

	// Digit store, least significant digit first.
	i2a_ram #(
		.WIDTH(CHAR_W),
		.DEPTH(MAX_DIGITS)
	) u_digit_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (cnt_q[ADDR_W-1:0]),
		.wdata (peel_char),
		.raddr (idx_d),
		.rdata (ram_rdata)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (emit) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			m_data_q <= emit_char;
			m_last_q <= emit_last;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tlast  = m_last_q;

	// The digit count never runs past the store.
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q <= CNT_W'(MAX_DIGITS)))
		else $error("digit count beyond store depth");

	// At least one digit is stored before emission is set up.
	a_prep_digits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PREP) |-> (cnt_q != '0))
		else $error("no digit stored at setup");

	// Padding state is only entered with padding left to send.
	a_pad_left: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PAD) |-> (pad_q != '0))
		else $error("padding state with no padding left");

	// Handing over the final digit returns the block to idle.
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && emit_last) |=> (state_q == ST_IDLE))
		else $error("sequencer not idle after final character");

endmodule

`default_nettype wire

/* tb/sv/tb.sv */
// Self-checking testbench for the integer-to-ASCII formatter top level.
`timescale 1ns / 1ps

module tb;
	import i2a_pkg::*;

	// A run of this many cycles with no request and no character taken ends the run.
	localparam int STALL_LIMIT = 5000;
	// Cycles to wait after the last expected character before ending.
	localparam int DRAIN_CYCLES = 200;
	localparam int RANDOM_REQUESTS = 420;

	typedef struct {
		logic [FUNC_W-1:0]  kind;
		logic [VALUE_W-1:0] value;
		logic [FW_W-1:0]    min_width;
		logic               zero_pad;
	} fmt_request_t;

	typedef struct {
		logic [CHAR_W-1:0] ch;
		logic              last;
	} text_char_t;

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [IN_DATA_W-1:0] s_tdata;
	logic [FUNC_W-1:0]    s_tuser;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [CHAR_W-1:0]    m_tdata;
	logic                 m_tlast;

	fmt_request_t pending_requests [$];
	text_char_t   expected_text [$];
	fmt_request_t driven_rq;
	fmt_request_t taken_rq;
	text_char_t   want;
	logic         req_taken;
	int           text_errors;
	int           idle_cycles;
	int           burst_left;
	int           gap_left;
	int           ready_mode;
	int           mode_left;
	int unsigned  tick;

	integer_to_ascii_formatter_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always #10 clk = ~clk;

	// Appends one request to the stimulus queue.
	function automatic void add_request(input logic [FUNC_W-1:0] kind,
			input logic [VALUE_W-1:0] value, input logic [FW_W-1:0] min_width,
			input logic zero_pad);
		fmt_request_t rq;
		rq.kind      = kind;
		rq.value     = value;
		rq.min_width = min_width;
		rq.zero_pad  = zero_pad;
		pending_requests.push_back(rq);
	endfunction

	// Works out the text that one request produces and queues it as expected characters.
	function automatic void predict_text(input fmt_request_t rq);
		logic [VALUE_W-1:0] mag;
		logic [31:0]        lo;
		logic [VALUE_W-1:0] digit;
		logic [CHAR_W-1:0]  digits [$];
		logic [CHAR_W-1:0]  text [$];
		logic [CHAR_W-1:0]  x_char;
		logic               neg;
		logic               upper;
		int unsigned        radix;
		int unsigned        fw;
		int unsigned        len;
		int unsigned        fill;
		text_char_t         tc;

		neg    = 1'b0;
		upper  = 1'b0;
		x_char = '0;
		radix  = 16;
		fw     = (rq.min_width > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : rq.min_width;
		mag    = {32'b0, rq.value[31:0]};
		case (rq.kind)
			FN_NONE: begin
				return;
			end
			FN_DEC32: begin
				radix = 10;
				lo = rq.value[31:0];
				if (lo[31]) begin
					neg = 1'b1;
					lo = -lo;
				end
				mag = {32'b0, lo};
			end
			FN_DEC64: begin
				radix = 10;
				mag = rq.value;
				if (mag[63]) begin
					neg = 1'b1;
					mag = -mag;
				end
			end
			FN_HEX32: begin
				x_char = CH_X_LO;
			end
			FN_HEX64: begin
				x_char = CH_X_LO;
				mag = rq.value;
			end
			FN_HEXU32: begin
				x_char = CH_X_UP;
				upper = 1'b1;
			end
			FN_BIN32: begin
				radix = 2;
			end
			default: begin
				// Pointer: the prefix eats two columns of the field width.
				x_char = CH_X_LO;
				fw = (fw > 2) ? fw - 2 : 0;
			end
		endcase

		// Digits, most significant first.
		if (mag == 0)
			digits.push_back(CH_ZERO);
		while (mag != 0) begin
			digit = mag % radix;
			mag = mag / radix;
			if (digit < 10)
				digits.push_front(CH_ZERO + digit[7:0]);
			else
				digits.push_front((upper ? CH_A_UP : CH_A_LO) + digit[7:0] - 8'd10);
		end

		len  = digits.size() + (neg ? 1 : 0);
		fill = (fw > len) ? fw - len : 0;

		// Prefix first, then the sign ahead of zero padding, the padding, the sign after space padding, and the digits.
		if (x_char != '0) begin
			text.push_back(CH_ZERO);
			text.push_back(x_char);
		end
		if (neg && rq.zero_pad && fill > 0) begin
			text.push_back(CH_MINUS);
			neg = 1'b0;
		end
		repeat (fill)
			text.push_back(rq.zero_pad ? CH_ZERO : CH_SPACE);
		if (neg)
			text.push_back(CH_MINUS);
		foreach (digits[i])
			text.push_back(digits[i]);

		foreach (text[i]) begin
			tc.ch   = text[i];
			tc.last = (i == text.size() - 1);
			expected_text.push_back(tc);
		end
	endfunction

	// Request driver: bursts of back-to-back requests separated by random gaps.
	always @(negedge clk) begin
		if (arst_n && !(s_tvalid && !req_taken)) begin
			if (gap_left > 0) begin
				gap_left = gap_left - 1;
				s_tvalid <= 1'b0;
			end else if (pending_requests.size() > 0) begin
				driven_rq = pending_requests.pop_front();
				s_tuser  <= driven_rq.kind;
				s_tdata  <= {1'b0, driven_rq.zero_pad, driven_rq.min_width, driven_rq.value};
				s_tvalid <= 1'b1;
				if (burst_left > 0) begin
					burst_left = burst_left - 1;
				end else begin
					burst_left = $urandom_range(0, 12);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
				end
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Character sink: the stall pattern switches between random modes at random times.
	always @(negedge clk) begin
		tick = tick + 1;
		if (mode_left == 0) begin
			ready_mode = $urandom_range(0, 3);
			mode_left = $urandom_range(20, 300);
		end else begin
			mode_left = mode_left - 1;
		end
		case (ready_mode)
			0: m_tready <= 1'b1;
			1: m_tready <= ($urandom_range(0, 1) == 1);
			2: m_tready <= ($urandom_range(0, 3) == 0);
			default: m_tready <= tick[2];
		endcase
	end

	// Monitor: predicts each taken request, checks each taken character, and runs the watchdog.
	always @(posedge clk) begin
		if (arst_n) begin
			req_taken <= s_tvalid && s_tready;
			if (s_tvalid && s_tready) begin
				taken_rq.kind      = s_tuser;
				taken_rq.value     = s_tdata[63:0];
				taken_rq.min_width = s_tdata[69:64];
				taken_rq.zero_pad  = s_tdata[70];
				predict_text(taken_rq);
			end
			if (m_tvalid && m_tready) begin
				if (expected_text.size() == 0) begin
					$error("character: none expected, got %h (last %b)", m_tdata, m_tlast);
					text_errors = text_errors + 1;
				end else begin
					want = expected_text.pop_front();
					if (m_tdata !== want.ch) begin
						$error("character: expected %h, got %h", want.ch, m_tdata);
						text_errors = text_errors + 1;
					end
					if (m_tlast !== want.last) begin
						$error("last: expected %b, got %b", want.last, m_tlast);
						text_errors = text_errors + 1;
					end
				end
			end
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles = idle_cycles + 1;
				if (idle_cycles >= STALL_LIMIT) begin
					$display("integer_to_ascii_formatter_top regression: fail");
					$finish;
				end
			end
		end
	end

	initial begin
		logic [VALUE_W-1:0] value;
		logic [FUNC_W-1:0]  kind;
		logic [FW_W-1:0]    min_width;
		logic [31:0]        near_zero;

		clk         = 1'b0;
		arst_n      = 1'b0;
		s_tvalid    = 1'b0;
		s_tdata     = '0;
		s_tuser     = FN_DEC32;
		m_tready    = 1'b0;
		req_taken   = 1'b0;
		text_errors = 0;
		idle_cycles = 0;
		burst_left  = 0;
		gap_left    = 0;
		ready_mode  = 0;
		mode_left   = 0;
		tick        = 0;

		// Directed cases: extremes, every kind, and the special cases.
		add_request(FN_DEC32, 64'h0, 6'd0, 1'b0);
		add_request(FN_DEC32, 64'hFFFF_FFFF_8000_0000, 6'd0, 1'b0);
		add_request(FN_DEC32, 64'h0000_0000_7FFF_FFFF, 6'd12, 1'b0);
		add_request(FN_DEC32, 64'hFFFF_FFFF_FFFF_FFFB, 6'd2, 1'b1);
		add_request(FN_DEC32, 64'h0000_0000_FFFF_FFFB, 6'd5, 1'b1);
		add_request(FN_DEC32, 64'h0000_0000_FFFF_FFFB, 6'd6, 1'b0);
		add_request(FN_DEC64, 64'h8000_0000_0000_0000, 6'd0, 1'b0);
		add_request(FN_DEC64, 64'h7FFF_FFFF_FFFF_FFFF, 6'd25, 1'b1);
		add_request(FN_DEC64, 64'hFFFF_FFFF_FFFF_FFFF, 6'd63, 1'b1);
		add_request(FN_DEC64, 64'h0, 6'd63, 1'b0);
		add_request(FN_HEX32, 64'h1234_5678_DEAD_BEEF, 6'd12, 1'b1);
		add_request(FN_HEX32, 64'h0, 6'd0, 1'b0);
		add_request(FN_HEX64, 64'hFFFF_FFFF_FFFF_FFFF, 6'd0, 1'b0);
		add_request(FN_HEX64, 64'h0, 6'd63, 1'b0);
		add_request(FN_HEXU32, 64'h0000_0000_ABCD_EF01, 6'd0, 1'b0);
		add_request(FN_HEXU32, 64'h0000_0000_0000_00FA, 6'd9, 1'b1);
		add_request(FN_BIN32, 64'h0000_0000_FFFF_FFFF, 6'd0, 1'b0);
		add_request(FN_BIN32, 64'h0, 6'd3, 1'b1);
		add_request(FN_BIN32, 64'h0000_0000_8000_0000, 6'd40, 1'b1);
		add_request(FN_PTR, 64'h0000_0000_0000_BEEF, 6'd0, 1'b1);
		add_request(FN_PTR, 64'h0000_0000_0000_00AB, 6'd2, 1'b1);
		add_request(FN_PTR, 64'h0000_0000_0000_00AB, 6'd3, 1'b1);
		add_request(FN_PTR, 64'hFFFF_FFFF_FFFF_FFFF, 6'd63, 1'b0);
		add_request(FN_NONE, 64'hFFFF_FFFF_FFFF_FFFF, 6'd63, 1'b1);
		add_request(FN_NONE, 64'h0, 6'd0, 1'b0);

		// Random requests with values shaped toward small, negative and extreme numbers.
		for (int n = 0; n < RANDOM_REQUESTS; n++) begin
			near_zero = $urandom_range(0, 20);
			case ($urandom_range(0, 5))
				0: value = {$urandom, near_zero};
				1: value = -{32'b0, near_zero};
				2: value = {$urandom, -near_zero};
				3: value = {$urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF,
						$urandom_range(0, 1) ? 32'h0 : 32'hFFFF_FFFF} ^ {32'b0, near_zero};
				default: value = {$urandom, $urandom};
			endcase
			kind = ($urandom_range(0, 29) == 0) ? FN_NONE : FUNC_W'($urandom_range(0, 6));
			min_width = ($urandom_range(0, 7) == 0) ? FW_W'($urandom_range(25, 63))
				: FW_W'($urandom_range(0, 24));
			add_request(kind, value, min_width, 1'($urandom_range(0, 1)));
		end

		// Hold reset, then release it on a falling edge, away from the sampling edge.
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Wait for all requests to be taken and all text to arrive, then drain.
		@(posedge clk);
		while (pending_requests.size() != 0 || s_tvalid)
			@(posedge clk);
		while (expected_text.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (text_errors == 0) begin
			$display("integer_to_ascii_formatter_top regression: pass");
		end else begin
			$display("integer_to_ascii_formatter_top regression: fail");
		end
		$finish;
	end

endmodule

/* sim.f */
sv/i2a_pkg.sv
sv/i2a_ram.sv
sv/integer_to_ascii_formatter_top.sv
tb/sv/tb.sv
